@@ rtl/sd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sd_pkg: shared constants and table functions
// Register indexes, fixed-point constants and the log2 / exp2 table
// generators used by the de-esser lookups.
// ----------------------------------------------------------------------------
package sd_pkg;

    // configuration register indexes
    localparam logic [3:0] CFG_BAND_GAIN   = 4'd0;
    localparam logic [3:0] CFG_FEEDBACK1   = 4'd1;
    localparam logic [3:0] CFG_FEEDBACK2   = 4'd2;
    localparam logic [3:0] CFG_ATTACK      = 4'd3;
    localparam logic [3:0] CFG_RELEASE     = 4'd4;
    localparam logic [3:0] CFG_THRESHOLD   = 4'd5;
    localparam logic [3:0] CFG_SLOPE       = 4'd6;
    localparam logic [3:0] CFG_MAKEUP      = 4'd7;

    // 20*log10(2) in Q.16 and log2(10)/20 in Q.16
    localparam logic signed [31:0] DB_PER_LOG2 = 32'sd394566;
    localparam logic signed [31:0] LOG2_PER_DB = 32'sd10885;
    // level used for a silent envelope, -200 dB in Q10.8
    localparam logic signed [17:0] FLOOR_LEVEL = -18'sd51200;
    localparam logic [14:0] RED_MAX = 15'd32767;
    localparam logic [14:0] HIT_LIMIT = 15'd25;

    // 2^(2^-k) in Q1.30 for k >= 1; entry 0 holds 1.0
    localparam logic [63:0] ROOT_POW [13] = '{
        64'd1073741824, 64'd1518500250, 64'd1276901417, 64'd1170923762,
        64'd1121280436, 64'd1097253708, 64'd1085434106, 64'd1079572136,
        64'd1076653033, 64'd1075196443, 64'd1074468888, 64'd1074105294,
        64'd1073923544
    };

    // log2(1 + idx/2^bits) in Q0.16, truncated, by repeated squaring
    function automatic logic [15:0] log_entry(input int unsigned idx,
                                              input int unsigned bits);
        logic [63:0] m;
        logic [15:0] r;
        m = (64'd1 << 30) + (64'(idx) << (30 - bits));
        r = '0;
        for (int k = 15; k >= 0; k--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    // 2^(idx/2^bits) in Q1.30, product of root constants
    function automatic logic [30:0] exp_entry(input int unsigned idx,
                                              input int unsigned bits);
        logic [63:0] m;
        m = 64'd1 << 30;
        for (int k = 1; k <= int'(bits); k++)
        begin
            if (((idx >> (bits - k)) & 1) != 0)
                m = (m * ROOT_POW[k] + (64'd1 << 29)) >> 30;
        end
        return m[30:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/sd_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sd_mul: shared signed multiplier
// One registered 25 x 32 signed multiply, reused by the multiply steps of the sequencer.
// ----------------------------------------------------------------------------
module sd_mul (
    input  wire logic               clk,
    input  wire logic signed [24:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [56:0]      p
);

    logic signed [56:0] p_reg;
    logic signed [56:0] p_next;

    // product of the selected operands
    assign p_next = 57'(a) * 57'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

@@ rtl/sd_log_lut.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sd_log_lut: log2 mantissa table
// Constant table of log2(1 + i/2^BITS) in Q0.16.
// ----------------------------------------------------------------------------
module sd_log_lut #(
    parameter int BITS = 8
) (
    input  wire logic [BITS-1:0] idx,
    output logic [15:0]          value
);

    localparam int SIZE = 1 << BITS;

    logic [15:0] tab [SIZE];

    // table entries fixed at elaboration
    for (genvar g = 0; g < SIZE; g++)
    begin : g_entry
        assign tab[g] = sd_pkg::log_entry(g, BITS);
    end

    assign value = tab[idx];

endmodule
`default_nettype wire

@@ rtl/sd_exp_lut.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sd_exp_lut: exp2 mantissa table
// Constant table of 2^(i/2^BITS) in Q1.30.
// ----------------------------------------------------------------------------
module sd_exp_lut #(
    parameter int BITS = 8
) (
    input  wire logic [BITS-1:0] idx,
    output logic [30:0]          value
);

    localparam int SIZE = 1 << BITS;

    logic [30:0] tab [SIZE];

    // table entries fixed at elaboration
    for (genvar g = 0; g < SIZE; g++)
    begin : g_entry
        assign tab[g] = sd_pkg::exp_entry(g, BITS);
    end

    assign value = tab[idx];

endmodule
`default_nettype wire

@@ rtl/sibilance_deesser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sibilance_deesser: band-pass sidechain de-esser
// Biquad sidechain, envelope follower, dB level, gain reduction and output
// gain, all sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
// Each sample runs from acceptance through B0, A1, A2, Y, ENV, LVL, LOG, RED,
// GAIN, MANT and OUT to a loaded result, and the sequencer returns to idle
// before it takes the next sample. The shared 25 x 32 multiplier is used eight
// times per sample (three biquad taps, envelope step, dB scaling, slope, gain
// exponent, output scaling) and the sequencer walks through its states one per
// cycle, save for the hold in its last state. in_stall is high while a sample
// is in work. The result sits in an output register, so a new sample is taken
// while the previous result waits; the sequencer holds in its last state only
// if the older result has still not been taken, and re-issues the output
// scaling from a registered mantissa while it holds.
module sibilance_deesser #(
    parameter int LOG_TABLE_BITS = 8,
    parameter int EXP_TABLE_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] in_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      out_sample,
    output logic [14:0]             reduction_db,
    output logic                    sibilance_hit,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [17:0]        cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_B0   = 12'b0000_0000_0010,
        ST_A1   = 12'b0000_0000_0100,
        ST_A2   = 12'b0000_0000_1000,
        ST_Y    = 12'b0000_0001_0000,
        ST_ENV  = 12'b0000_0010_0000,
        ST_LVL  = 12'b0000_0100_0000,
        ST_LOG  = 12'b0000_1000_0000,
        ST_RED  = 12'b0001_0000_0000,
        ST_GAIN = 12'b0010_0000_0000,
        ST_MANT = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [17:0] b0_reg, a1_reg, a2_reg;
    logic [15:0]        attack_reg, release_reg, slope_reg;
    logic signed [15:0] thr_reg;
    logic signed [13:0] makeup_reg;

    // filter and envelope state
    logic signed [15:0] xh0_reg, xh1_reg, x_reg;
    logic signed [23:0] yh0_reg, yh1_reg;
    logic [15:0]        env_reg;
    logic signed [57:0] acc_reg;
    logic               gt_reg, ge_reg;
    logic [14:0]        red_reg;
    logic signed [6:0]  n_reg;
    logic [30:0]        mant_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic [14:0]        red_out_reg;
    logic               hit_out_reg;

    // shared multiplier
    logic signed [24:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [56:0] mul_p;

    sd_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // datapath signals
    logic signed [16:0] dx;
    logic signed [57:0] acc_sub, y_rnd;
    logic signed [23:0] y_sat;
    logic signed [24:0] y_abs;
    logic [15:0]        mag, diff;
    logic               gt;
    logic [32:0]        env_step;
    logic [15:0]        env_next;
    logic [3:0]         lead;
    logic [31:0]        norm;
    logic [LOG_TABLE_BITS-1:0] log_idx;
    logic [15:0]        log_val;
    logic signed [20:0] lg;
    logic signed [56:0] lvl_rnd;
    logic signed [17:0] lvl, thr_ext, over;
    logic               ge;
    logic [33:0]        red_raw;
    logic [14:0]        red;
    logic signed [56:0] e_full;
    logic signed [40:0] n_full;
    logic signed [6:0]  n_sat;
    logic [EXP_TABLE_BITS-1:0] exp_idx;
    logic [30:0]        mant;
    logic [5:0]         sh;
    logic signed [63:0] o_rnd;
    logic signed [15:0] o_sat;
    logic               in_acc, out_acc;

    sd_log_lut #(.BITS(LOG_TABLE_BITS)) u_log (
        .idx   (log_idx),
        .value (log_val)
    );

    sd_exp_lut #(.BITS(EXP_TABLE_BITS)) u_exp (
        .idx   (exp_idx),
        .value (mant)
    );

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;

    // biquad accumulation and output saturation
    always_comb
    begin
        dx = 17'(x_reg) - 17'(xh1_reg);
        acc_sub = acc_reg - 58'(mul_p);
        y_rnd = (acc_sub + 58'sd32768) >>> 16;
        if (y_rnd > 58'sd8388607)
            y_sat = 24'sh7FFFFF;
        else if (y_rnd < -58'sd8388608)
            y_sat = -24'sh800000;
        else
            y_sat = y_rnd[23:0];
    end

    // magnitude and envelope step
    always_comb
    begin
        y_abs = (yh0_reg < 0) ? -25'(yh0_reg) : 25'(yh0_reg);
        mag = (y_abs > 25'sd65535) ? 16'hFFFF : y_abs[15:0];
        gt = mag > env_reg;
        diff = gt ? (mag - env_reg) : (env_reg - mag);
        env_step = mul_p[32:0] + 33'd32768;
        env_next = gt_reg ? (env_reg + env_step[31:16]) : (env_reg - env_step[31:16]);
    end

    // leading one and log2 of the envelope
    always_comb
    begin
        lead = '0;
        for (int b = 0; b < 16; b++)
        begin
            if (env_reg[b])
                lead = 4'(b);
        end
        norm = {env_reg, 16'd0} >> (5'(lead) + 5'd16 - 5'(LOG_TABLE_BITS));
        log_idx = norm[LOG_TABLE_BITS-1:0];
        lg = signed'({5'(lead) - 5'd15, log_val});
    end

    // level, threshold compare and reduction
    always_comb
    begin
        lvl_rnd = (mul_p + 57'sd8388608) >>> 24;
        lvl = (env_reg == 16'd0) ? sd_pkg::FLOOR_LEVEL : lvl_rnd[17:0];
        thr_ext = 18'(thr_reg);
        ge = lvl >= thr_ext;
        over = lvl - thr_ext;
        red_raw = mul_p[33:0] + 34'd32768;
        if (!ge_reg)
            red = '0;
        else if (red_raw[33:16] > 18'(sd_pkg::RED_MAX))
            red = sd_pkg::RED_MAX;
        else
            red = red_raw[30:16];
    end

    // gain exponent split into shift and mantissa index
    always_comb
    begin
        e_full = (mul_p + 57'sd128) >>> 8;
        n_full = e_full[56:16];
        if (n_full < -41'sd33)
            n_sat = -7'sd33;
        else if (n_full > 41'sd8)
            n_sat = 7'sd8;
        else
            n_sat = n_full[6:0];
        exp_idx = e_full[15 -: EXP_TABLE_BITS];
    end

    // output rounding shift and saturation
    always_comb
    begin
        sh = 6'(7'sd30 - n_reg);
        o_rnd = (64'(mul_p) + (64'sd1 <<< (sh - 6'd1))) >>> sh;
        if (o_rnd > 64'sd32767)
            o_sat = 16'sh7FFF;
        else if (o_rnd < -64'sd32768)
            o_sat = -16'sh8000;
        else
            o_sat = o_rnd[15:0];
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_B0:
            begin
                mul_a = 25'(dx);
                mul_b = 32'(b0_reg);
            end
            ST_A1:
            begin
                mul_a = 25'(yh0_reg);
                mul_b = 32'(a1_reg);
            end
            ST_A2:
            begin
                mul_a = 25'(yh1_reg);
                mul_b = 32'(a2_reg);
            end
            ST_ENV:
            begin
                mul_a = signed'({9'd0, diff});
                mul_b = signed'({16'd0, gt ? attack_reg : release_reg});
            end
            ST_LOG:
            begin
                mul_a = 25'(lg);
                mul_b = sd_pkg::DB_PER_LOG2;
            end
            ST_RED:
            begin
                mul_a = 25'(over);
                mul_b = signed'({16'd0, slope_reg});
            end
            ST_GAIN:
            begin
                mul_a = 25'(makeup_reg) - signed'({10'd0, red});
                mul_b = sd_pkg::LOG2_PER_DB;
            end
            ST_MANT:
            begin
                mul_a = 25'(x_reg);
                mul_b = signed'({1'b0, mant});
            end
            // keep the output product alive while the result waits
            ST_OUT:
            begin
                mul_a = 25'(x_reg);
                mul_b = signed'({1'b0, mant_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_B0;
            ST_B0:   state_next = ST_A1;
            ST_A1:   state_next = ST_A2;
            ST_A2:   state_next = ST_Y;
            ST_Y:    state_next = ST_ENV;
            ST_ENV:  state_next = ST_LVL;
            ST_LVL:  state_next = ST_LOG;
            ST_LOG:  state_next = ST_RED;
            ST_RED:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_MANT;
            ST_MANT: state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg      <= '0;
            a1_reg      <= '0;
            a2_reg      <= '0;
            attack_reg  <= 16'd65535;
            release_reg <= 16'd655;
            thr_reg     <= -16'sd7680;
            slope_reg   <= 16'd49152;
            makeup_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sd_pkg::CFG_BAND_GAIN: b0_reg      <= cfg_data;
                sd_pkg::CFG_FEEDBACK1: a1_reg      <= cfg_data;
                sd_pkg::CFG_FEEDBACK2: a2_reg      <= cfg_data;
                sd_pkg::CFG_ATTACK:    attack_reg  <= cfg_data[15:0];
                sd_pkg::CFG_RELEASE:   release_reg <= cfg_data[15:0];
                sd_pkg::CFG_THRESHOLD: thr_reg     <= cfg_data[15:0];
                sd_pkg::CFG_SLOPE:     slope_reg   <= cfg_data[15:0];
                sd_pkg::CFG_MAKEUP:    makeup_reg  <= cfg_data[13:0];
                default:               ;
            endcase
        end
    end

    // filter and envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh0_reg <= '0;
            xh1_reg <= '0;
            yh0_reg <= '0;
            yh1_reg <= '0;
            env_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_Y)
            begin
                xh1_reg <= xh0_reg;
                xh0_reg <= x_reg;
                yh1_reg <= yh0_reg;
                yh0_reg <= y_sat;
            end
            if (state_reg == ST_LVL)
                env_reg <= env_next;
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            x_reg <= in_sample;
        if (state_reg == ST_A1)
            acc_reg <= 58'(mul_p);
        if (state_reg == ST_A2)
            acc_reg <= acc_sub;
        if (state_reg == ST_ENV)
            gt_reg <= gt;
        if (state_reg == ST_RED)
            ge_reg <= ge;
        if (state_reg == ST_GAIN)
            red_reg <= red;
        if (state_reg == ST_MANT)
        begin
            n_reg    <= n_sat;
            mant_reg <= mant;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
            out_valid_reg <= 1'b1;
        else if (out_acc)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
        begin
            out_sample_reg <= o_sat;
            red_out_reg    <= red_reg;
            hit_out_reg    <= red_reg > sd_pkg::HIT_LIMIT;
        end
    end

    assign in_stall      = state_reg != ST_IDLE;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign out_sample    = out_sample_reg;
    assign reduction_db  = red_out_reg;
    assign sibilance_hit = hit_out_reg;

    // a fresh result only comes out of the last step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the final step");

    // an accepted item starts the biquad
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_B0)
        else $error("accepted item did not start the sequence");

    // flag agrees with the reported reduction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hit_out_reg == (red_out_reg > sd_pkg::HIT_LIMIT)))
        else $error("sibilance flag disagrees with reduction");

    // envelope only changes in its update step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LVL) |=> $stable(env_reg))
        else $error("envelope changed outside its update step");

endmodule
`default_nettype wire
